[hdl/mpdq_pkg.sv]
// shared types and codes for the mouse packet deframer queue
package mpdq_pkg;

  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_POLL = 1'b1;

  localparam int SYNC_BIT = 3;

  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 40;

  // one queued event, button byte in the lowest bits
  typedef struct packed {
    logic [7:0] z_move;
    logic [7:0] y_move;
    logic [7:0] x_move;
    logic [7:0] button_byte;
  } event_t;

  localparam int EVENT_W = $bits(event_t);

  // framer to queue: completed packet
  typedef struct packed {
    logic   push;
    event_t ev;
  } push_req_t;

  // queue to top: outcome of the current word
  typedef struct packed {
    logic hit;
    logic drop;
  } queue_status_t;

endpackage

[hdl/mpdq_ram.sv]
// generic single write port ram with registered read
module mpdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/mpdq_framer.sv]
// byte framing: sync check and packet assembly
module mpdq_framer
  import mpdq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      take,
  input  logic      mode,
  input  logic [7:0] rx_byte,
  input  logic      wheel_enabled,
  output push_req_t push_req,
  output logic      sync_error
);

  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_THIRD  = 2'd2;
  localparam logic [1:0] PH_WHEEL  = 2'd3;

  logic [1:0] phase;
  logic [1:0] phase_next;
  logic [7:0] pkt [3];
  logic       byte_in;

  assign byte_in = take && (mode == MODE_BYTE);

  always_comb begin
    phase_next    = phase;
    sync_error    = 1'b0;
    push_req.push = 1'b0;
    push_req.ev   = '{z_move: 8'd0, y_move: rx_byte, x_move: pkt[1], button_byte: pkt[0]};
    unique case (phase)
      PH_FIRST: begin
        if (rx_byte[SYNC_BIT]) begin
          phase_next = PH_SECOND;
        end else begin
          sync_error = byte_in;
        end
      end
      PH_SECOND: phase_next = PH_THIRD;
      PH_THIRD: begin
        if (wheel_enabled) begin
          phase_next = PH_WHEEL;
        end else begin
          phase_next    = PH_FIRST;
          push_req.push = byte_in;
        end
      end
      PH_WHEEL: begin
        phase_next    = PH_FIRST;
        push_req.push = byte_in;
        push_req.ev   = '{z_move: rx_byte, y_move: pkt[2], x_move: pkt[1],
                          button_byte: pkt[0]};
      end
      default: phase_next = PH_FIRST;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_FIRST;
    end else if (byte_in) begin
      phase <= phase_next;
    end
  end

  // packet byte registers for the first three positions; the wheel byte is taken straight from rx_byte
  always_ff @(posedge clk) begin
    if (rst) begin
      pkt[0] <= '0;
      pkt[1] <= '0;
      pkt[2] <= '0;
    end else if (byte_in) begin
      if (phase == PH_FIRST && rx_byte[SYNC_BIT]) begin
        pkt[0] <= rx_byte;
      end
      if (phase == PH_SECOND) begin
        pkt[1] <= rx_byte;
      end
      if (phase == PH_THIRD) begin
        pkt[2] <= rx_byte;
      end
    end
  end

endmodule

[hdl/mpdq_queue.sv]
// ring queue of events with one slot kept empty
module mpdq_queue
  import mpdq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          take,
  input  logic          mode,
  input  push_req_t     push_req,
  output queue_status_t status,
  output event_t        rdata
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam logic [AW-1:0] LAST = AW'(QUEUE_DEPTH - 1);

  logic [AW-1:0] write_index;
  logic [AW-1:0] read_index;
  logic [AW-1:0] write_index_next;
  logic [AW-1:0] read_index_next;
  logic          full;
  logic          empty;
  logic          we;
  logic          re;

  assign write_index_next = (write_index == LAST) ? '0 : write_index + 1'b1;
  assign read_index_next  = (read_index == LAST) ? '0 : read_index + 1'b1;
  assign full             = (write_index_next == read_index);
  assign empty            = (write_index == read_index);

  assign re          = take && (mode == MODE_POLL) && !empty;
  assign we          = push_req.push && !full;
  assign status.hit  = re;
  assign status.drop = push_req.push && full;

  always_ff @(posedge clk) begin
    if (rst) begin
      write_index <= '0;
      read_index  <= '0;
    end else begin
      if (we) begin
        write_index <= write_index_next;
      end
      if (re) begin
        read_index <= read_index_next;
      end
    end
  end

  // a pop never reads the slot being written: that slot lies outside the filled range
  mpdq_ram #(
    .WIDTH (EVENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (write_index),
    .wdata (push_req.ev),
    .re    (re),
    .raddr (read_index),
    .rdata (rdata)
  );

endmodule

[hdl/mouse_packet_deframer_queue.sv]
// top level: mouse packet deframer with event queue
//
// channel  dir  handshake            payload
// s_       in   s_tvalid/s_tready    s_tdata rx_byte, s_tuser mode
// m_       out  m_tvalid/m_tready    m_tdata event and flags, m_tuser event_valid
// cfg_     in   cfg_valid/cfg_ready  cfg_data wheel_enabled
//
// one word per cycle while the output is not stalled; each word gives exactly one result word
// each word passes the store read stage, then the output register
// the event store is a ram with registered read, read at the pop pointer
// synchronous active high reset clears framing, pointers, the wheel setting and the pipeline valids
// a stalled output holds the store read stage; input is still taken while that stage is empty
module mouse_packet_deframer_queue
  import mpdq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // [7:0] rx_byte
  input  logic                  s_tuser,   // [0] mode
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // [7:0] button_byte, [15:8] x_move,
                                           // [23:16] y_move, [31:24] z_move,
                                           // [32] sync_error, [33] event_dropped
  output logic                  m_tuser,   // [0] event_valid
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_data   // [0] wheel_enabled
);

  logic          wheel_enabled;
  logic          take;
  push_req_t     push_req;
  logic          sync_error;
  queue_status_t qstat;
  event_t        rdata;

  // store read stage
  logic s1_valid;
  logic s1_hit;
  logic s1_serr;
  logic s1_drop;
  logic s1_move;

  event_t ev_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wheel_enabled <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      wheel_enabled <= cfg_data;
    end
  end

  // output register free, or being drained this cycle
  assign s1_move  = !m_tvalid || m_tready;
  assign s_tready = !s1_valid || s1_move;
  assign take     = s_tvalid && s_tready;

  mpdq_framer u_framer (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .mode          (s_tuser),
    .rx_byte       (s_tdata),
    .wheel_enabled (wheel_enabled),
    .push_req      (push_req),
    .sync_error    (sync_error)
  );

  mpdq_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .mode     (s_tuser),
    .push_req (push_req),
    .status   (qstat),
    .rdata    (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_hit  <= qstat.hit;
      s1_serr <= sync_error;
      s1_drop <= qstat.drop;
    end
  end

  // event fields read as zero unless a poll found an event
  assign ev_out = s1_hit ? rdata : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_move) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && s1_valid) begin
      m_tdata <= {6'd0, s1_drop, s1_serr, ev_out};
      m_tuser <= s1_hit;
    end
  end

endmodule
